// ----- sv/letm_pkg.sv -----
// Package: shared widths, types, codes and index tables for the tangent matrix block.
package letm_pkg;

   localparam int GW        = 32;
   localparam int EW        = 48;
   localparam int E_W       = 40;
   localparam int NU_W      = 15;
   localparam int CSR_W     = 40;
   localparam int CSR_IDX_W = 1;
   localparam int Q_FRAC    = 16;

   localparam int ROW_W     = 3;
   localparam int NUM_LANES = 6;
   localparam int MIDX_W    = 2;
   localparam logic [ROW_W-1:0] LAST_ROW = 3'd5;

   localparam int PW       = 2 * GW;
   localparam int SW       = PW + 1;
   localparam int SPLIT_W  = 32;
   localparam int L1W      = 54;
   localparam int L2W      = 39;
   localparam int L1_LO_W  = 27;
   localparam int L1_HI_W  = L1W - L1_LO_W;
   localparam int L2_LO_W  = 20;
   localparam int L2_HI_W  = L2W - L2_LO_W;
   localparam int PPW      = 64;
   localparam int AW       = 120;
   localparam int FRAC_SHIFT = 32;
   localparam int QW       = AW - FRAC_SHIFT;
   localparam int STAGES   = 5;

   localparam logic [EW-1:0] SAT_MAX = {1'b0, {(EW-1){1'b1}}};
   localparam logic [EW-1:0] SAT_MIN = {1'b1, {(EW-1){1'b0}}};

   localparam int NUM_W   = E_W + NU_W;
   localparam int DIV_DW  = NUM_W + Q_FRAC;
   localparam int DIV_RW  = 34;
   localparam int DIV_CW  = $clog2(DIV_DW);
   localparam int ONE_W   = Q_FRAC + 1;
   localparam logic [ONE_W-1:0] ONE_Q16 = 17'h10000;

   localparam int FQ_DEPTH = 2;
   localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
   localparam int OQ_DEPTH = 8;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_YOUNGS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POISSON = 1'b1;

   typedef logic [0:2][0:2][GW-1:0] metric_type;

   typedef struct packed {
      logic       valid;
      metric_type metric;
   } queue_head_type;

   typedef struct packed {
      logic           busy;
      logic [L1W-1:0] l1;
      logic [L2W-1:0] l2;
   } lame_type;

   typedef struct packed {
      logic [ROW_W-1:0]               row;
      logic [NUM_LANES-1:0][EW-1:0]   entry;
      logic                           last;
   } rsp_row_type;

   typedef enum logic [1:0] {
      LAME_IDLE,
      LAME_PREP,
      LAME_DIV_L1,
      LAME_DIV_L2
   } lame_state_type;

   // first index of the pair for a row or column
   function automatic logic [MIDX_W-1:0] pair_a(input logic [ROW_W-1:0] idx);
      logic [MIDX_W-1:0] r;
      case (idx)
         3'd0:    r = 2'd0;
         3'd1:    r = 2'd1;
         3'd2:    r = 2'd2;
         3'd3:    r = 2'd1;
         3'd4:    r = 2'd2;
         3'd5:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   // second index of the pair for a row or column
   function automatic logic [MIDX_W-1:0] pair_b(input logic [ROW_W-1:0] idx);
      logic [MIDX_W-1:0] r;
      case (idx)
         3'd0:    r = 2'd0;
         3'd1:    r = 2'd0;
         3'd2:    r = 2'd0;
         3'd3:    r = 2'd1;
         3'd4:    r = 2'd1;
         3'd5:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- sv/letm_lame.sv -----
// Config registers and Lame constant unit: shared restoring divider, one quotient bit per cycle.
module letm_lame import letm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data,
   output lame_type             lame
);

   lame_state_type state_ff, state_in;

   logic [E_W-1:0]    e_ff;
   logic [NU_W-1:0]   nu_ff;
   logic [L1W-1:0]    l1_ff, l1_in;
   logic [L2W-1:0]    l2_ff, l2_in;
   logic [DIV_RW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] dq_ff, dq_in;
   logic [DIV_RW-1:0] div_ff, div_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;

   logic [DIV_RW-1:0] rem_sh, rem_step;
   logic [DIV_DW-1:0] dq_step;
   logic              qbit;
   logic [ONE_W-1:0]  nu_p, nu_m;
   logic [NUM_W-1:0]  num;
   logic [DIV_RW-1:0] den;
   logic              last_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ff  <= '0;
         nu_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_YOUNGS:  e_ff  <= csr_data[E_W-1:0];
            CSR_POISSON: nu_ff <= csr_data[NU_W-1:0];
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LAME_IDLE;
         l1_ff    <= '0;
         l2_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         l1_ff    <= l1_in;
         l2_ff    <= l2_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      div_ff <= div_in;
   end

   always_comb begin
      rem_sh = {rem_ff[DIV_RW-2:0], dq_ff[DIV_DW-1]};
      if (rem_sh >= div_ff) begin
         rem_step = rem_sh - div_ff;
         qbit     = 1'b1;
      end else begin
         rem_step = rem_sh;
         qbit     = 1'b0;
      end
      dq_step   = {dq_ff[DIV_DW-2:0], qbit};
      last_step = (cnt_ff == DIV_CW'(DIV_DW - 1));

      nu_p = ONE_Q16 + ONE_W'(nu_ff);
      nu_m = ONE_Q16 - ONE_W'({nu_ff, 1'b0});
      num  = NUM_W'(e_ff) * NUM_W'(nu_ff);
      den  = DIV_RW'(nu_p) * DIV_RW'(nu_m);

      state_in = state_ff;
      l1_in    = l1_ff;
      l2_in    = l2_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;

      case (state_ff)
         LAME_IDLE: ;
         LAME_PREP: begin
            dq_in    = {num, {Q_FRAC{1'b0}}};
            div_in   = den;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = LAME_DIV_L1;
         end
         LAME_DIV_L1: begin
            rem_in = rem_step;
            dq_in  = dq_step;
            cnt_in = cnt_ff + DIV_CW'(1);
            if (last_step) begin
               l1_in    = dq_step[L1W-1:0];
               dq_in    = DIV_DW'({e_ff, {Q_FRAC{1'b0}}});
               div_in   = DIV_RW'({nu_p, 1'b0});
               rem_in   = '0;
               cnt_in   = '0;
               state_in = LAME_DIV_L2;
            end
         end
         LAME_DIV_L2: begin
            rem_in = rem_step;
            dq_in  = dq_step;
            cnt_in = cnt_ff + DIV_CW'(1);
            if (last_step) begin
               l2_in    = dq_step[L2W-1:0];
               cnt_in   = '0;
               state_in = LAME_IDLE;
            end
         end
         default: state_in = LAME_IDLE;
      endcase

      // any write restarts the constant computation
      if (csr_write) begin
         state_in = LAME_PREP;
      end

      lame.busy = (state_ff != LAME_IDLE);
      lame.l1   = l1_ff;
      lame.l2   = l2_ff;
   end

endmodule

// ----- sv/letm_front.sv -----
// Front end: takes metric tensor transfers into a short queue ahead of the row engine.
module letm_front import letm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  metric_type     req_metric,
   input  logic           hold,
   input  logic           pop,
   output queue_head_type head
);

   metric_type            mem_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                  push;

   assign req_stall   = (cnt_ff == FQ_CNT_W'(FQ_DEPTH)) || hold;
   assign push        = req_valid && !req_stall;
   assign head.valid  = (cnt_ff != '0);
   assign head.metric = mem_ff[rd_ptr_ff];

   always_comb begin
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + FQ_CNT_W'(1);
         2'b01:   cnt_in = cnt_ff - FQ_CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FQ_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FQ_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_metric;
      end
   end

endmodule

// ----- sv/letm_lane.sv -----
// One column lane: metric products, split Lame multiplies, sum, floor shift and saturation.
module letm_lane import letm_pkg::*; (
   input  logic             clock,
   input  metric_type       g,
   input  logic [ROW_W-1:0] row,
   input  logic [ROW_W-1:0] col,
   input  logic [L1W-1:0]   l1,
   input  logic [L2W-1:0]   l2,
   output logic [EW-1:0]    entry
);

   logic [MIDX_W-1:0]    i, j, k, l;
   logic signed [GW-1:0] g_ij, g_kl, g_ik, g_jl, g_il, g_kj;

   logic signed [PW-1:0]  p1_ff, p2_ff, p3_ff, p1_in, p2_in, p3_in;
   logic signed [PW-1:0]  p1b_ff;
   logic signed [SW-1:0]  s_ff, s_in;

   logic signed [L1_HI_W:0]      l1_hi_s;
   logic signed [L1_LO_W:0]      l1_lo_s;
   logic signed [L2_HI_W:0]      l2_hi_s;
   logic signed [L2_LO_W:0]      l2_lo_s;
   logic signed [SPLIT_W-1:0]    p1_hi;
   logic signed [SPLIT_W:0]      p1_lo_s;
   logic signed [SW-SPLIT_W-1:0] s_hi;
   logic signed [SPLIT_W:0]      s_lo_s;

   logic signed [PPW-1:0] pa_hh_ff, pa_hl_ff, pa_lh_ff, pa_ll_ff;
   logic signed [PPW-1:0] pb_hh_ff, pb_hl_ff, pb_lh_ff, pb_ll_ff;
   logic signed [PPW-1:0] pa_hh_in, pa_hl_in, pa_lh_in, pa_ll_in;
   logic signed [PPW-1:0] pb_hh_in, pb_hl_in, pb_lh_in, pb_ll_in;

   logic signed [AW-1:0] a_ff, b_ff, a_in, b_in, t;
   logic [QW-1:0]        q;

   // stage 1: metric products for this row and column
   always_comb begin
      i = pair_a(row);
      j = pair_b(row);
      k = pair_a(col);
      l = pair_b(col);
      g_ij = g[i][j];
      g_kl = g[k][l];
      g_ik = g[i][k];
      g_jl = g[j][l];
      g_il = g[i][l];
      g_kj = g[k][j];
      p1_in = PW'(g_ij * g_kl);
      p2_in = PW'(g_ik * g_jl);
      p3_in = PW'(g_il * g_kj);
   end

   // stage 2: shear pair sum
   assign s_in = SW'(p2_ff) + SW'(p3_ff);

   // stage 3: partial products
   always_comb begin
      l1_hi_s = $signed({1'b0, l1[L1W-1:L1_LO_W]});
      l1_lo_s = $signed({1'b0, l1[L1_LO_W-1:0]});
      l2_hi_s = $signed({1'b0, l2[L2W-1:L2_LO_W]});
      l2_lo_s = $signed({1'b0, l2[L2_LO_W-1:0]});
      p1_hi   = $signed(p1b_ff[PW-1:SPLIT_W]);
      p1_lo_s = $signed({1'b0, p1b_ff[SPLIT_W-1:0]});
      s_hi    = $signed(s_ff[SW-1:SPLIT_W]);
      s_lo_s  = $signed({1'b0, s_ff[SPLIT_W-1:0]});

      pa_hh_in = PPW'(l1_hi_s * p1_hi);
      pa_hl_in = PPW'(l1_hi_s * p1_lo_s);
      pa_lh_in = PPW'(l1_lo_s * p1_hi);
      pa_ll_in = PPW'(l1_lo_s * p1_lo_s);
      pb_hh_in = PPW'(l2_hi_s * s_hi);
      pb_hl_in = PPW'(l2_hi_s * s_lo_s);
      pb_lh_in = PPW'(l2_lo_s * s_hi);
      pb_ll_in = PPW'(l2_lo_s * s_lo_s);
   end

   // stage 4: recombine partials
   always_comb begin
      a_in = (AW'(pa_hh_ff) <<< (L1_LO_W + SPLIT_W)) + (AW'(pa_hl_ff) <<< L1_LO_W)
           + (AW'(pa_lh_ff) <<< SPLIT_W) + AW'(pa_ll_ff);
      b_in = (AW'(pb_hh_ff) <<< (L2_LO_W + SPLIT_W)) + (AW'(pb_hl_ff) <<< L2_LO_W)
           + (AW'(pb_lh_ff) <<< SPLIT_W) + AW'(pb_ll_ff);
   end

   always_ff @(posedge clock) begin
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      p3_ff    <= p3_in;
      p1b_ff   <= p1_ff;
      s_ff     <= s_in;
      pa_hh_ff <= pa_hh_in;
      pa_hl_ff <= pa_hl_in;
      pa_lh_ff <= pa_lh_in;
      pa_ll_ff <= pa_ll_in;
      pb_hh_ff <= pb_hh_in;
      pb_hl_ff <= pb_hl_in;
      pb_lh_ff <= pb_lh_in;
      pb_ll_ff <= pb_ll_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
   end

   // floor to Q.16 and saturate to 48 bits
   always_comb begin
      t = a_ff + b_ff;
      q = t[AW-1:FRAC_SHIFT];
      if (q[QW-1:EW-1] == '0 || q[QW-1:EW-1] == '1) begin
         entry = q[EW-1:0];
      end else if (q[QW-1]) begin
         entry = SAT_MIN;
      end else begin
         entry = SAT_MAX;
      end
   end

endmodule

// ----- sv/letm_back.sv -----
// Back end: row sequencer, six column lanes and the credit-managed result queue.
module letm_back import letm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   input  lame_type       lame,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_row_type    rsp
);

   logic [ROW_W-1:0]    row_ff, row_in;
   metric_type          g0_ff;
   logic [STAGES-1:0]   vld_ff;
   logic [ROW_W-1:0]    rowp_ff [STAGES];

   rsp_row_type         oq_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] oq_wr_ff, oq_rd_ff;
   logic [OQ_CNT_W-1:0] oq_cnt_ff, oq_cnt_in;
   logic [OQ_CNT_W-1:0] used_ff, used_in;

   logic                         issue, out_pop, oq_push;
   logic [NUM_LANES-1:0][EW-1:0] lane_entry;
   rsp_row_type                  done_row;

   // a row issues only if its result has a reserved queue slot
   assign issue   = head.valid && (used_ff != OQ_CNT_W'(OQ_DEPTH));
   assign pop     = issue && (row_ff == LAST_ROW);
   assign out_pop = rsp_valid && !rsp_stall;
   assign oq_push = vld_ff[STAGES-1];

   assign rsp_valid = (oq_cnt_ff != '0);
   assign rsp       = oq_ff[oq_rd_ff];

   always_comb begin
      row_in = row_ff;
      if (issue) begin
         row_in = (row_ff == LAST_ROW) ? '0 : row_ff + ROW_W'(1);
      end
      case ({issue, out_pop})
         2'b10:   used_in = used_ff + OQ_CNT_W'(1);
         2'b01:   used_in = used_ff - OQ_CNT_W'(1);
         default: used_in = used_ff;
      endcase
      case ({oq_push, out_pop})
         2'b10:   oq_cnt_in = oq_cnt_ff + OQ_CNT_W'(1);
         2'b01:   oq_cnt_in = oq_cnt_ff - OQ_CNT_W'(1);
         default: oq_cnt_in = oq_cnt_ff;
      endcase
      done_row.row   = rowp_ff[STAGES-1];
      done_row.entry = lane_entry;
      done_row.last  = (rowp_ff[STAGES-1] == LAST_ROW);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         vld_ff    <= '0;
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
         used_ff   <= '0;
      end else begin
         row_ff    <= row_in;
         vld_ff    <= {vld_ff[STAGES-2:0], issue};
         oq_cnt_ff <= oq_cnt_in;
         used_ff   <= used_in;
         if (oq_push) begin
            oq_wr_ff <= oq_wr_ff + OQ_PTR_W'(1);
         end
         if (out_pop) begin
            oq_rd_ff <= oq_rd_ff + OQ_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         g0_ff <= head.metric;
      end
      rowp_ff[0] <= row_ff;
      for (int n = 1; n < STAGES; n++) begin
         rowp_ff[n] <= rowp_ff[n-1];
      end
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= done_row;
      end
   end

   for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
      letm_lane u_lane (
         .clock (clock),
         .g     (g0_ff),
         .row   (rowp_ff[0]),
         .col   (ROW_W'(c)),
         .l1    (lame.l1),
         .l2    (lame.l2),
         .entry (lane_entry[c])
      );
   end

endmodule

// ----- sv/linear_elastic_tangent_matrix.sv -----
// Top level: linear elastic tangent matrix, one metric tensor in, six matrix rows out.
// The first row passes the front queue, the metric and row registers, the lane pipeline
// and the result queue; rows issue one per cycle while the result queue has credit, and
// the front queue takes new tensors meanwhile. A config write recomputes the Lame constants
// on the shared divider; req_stall is high through its setup state and two divisions.
// Reset: queues empty, both config registers zero, so every entry reads zero.
module linear_elastic_tangent_matrix import letm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [GW-1:0] req_metric_00,
   input  logic signed [GW-1:0] req_metric_01,
   input  logic signed [GW-1:0] req_metric_02,
   input  logic signed [GW-1:0] req_metric_10,
   input  logic signed [GW-1:0] req_metric_11,
   input  logic signed [GW-1:0] req_metric_12,
   input  logic signed [GW-1:0] req_metric_20,
   input  logic signed [GW-1:0] req_metric_21,
   input  logic signed [GW-1:0] req_metric_22,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ROW_W-1:0]     rsp_row_index,
   output logic signed [EW-1:0] rsp_entry_0,
   output logic signed [EW-1:0] rsp_entry_1,
   output logic signed [EW-1:0] rsp_entry_2,
   output logic signed [EW-1:0] rsp_entry_3,
   output logic signed [EW-1:0] rsp_entry_4,
   output logic signed [EW-1:0] rsp_entry_5,
   output logic                 rsp_last_row,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   metric_type     req_metric;
   lame_type       lame;
   queue_head_type head;
   logic           pop;
   rsp_row_type    rsp;

   always_comb begin
      req_metric[0][0] = req_metric_00;
      req_metric[0][1] = req_metric_01;
      req_metric[0][2] = req_metric_02;
      req_metric[1][0] = req_metric_10;
      req_metric[1][1] = req_metric_11;
      req_metric[1][2] = req_metric_12;
      req_metric[2][0] = req_metric_20;
      req_metric[2][1] = req_metric_21;
      req_metric[2][2] = req_metric_22;
   end

   letm_lame u_lame (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .lame      (lame)
   );

   letm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_metric (req_metric),
      .hold       (lame.busy),
      .pop        (pop),
      .head       (head)
   );

   letm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .lame      (lame),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_row_index = rsp.row;
   assign rsp_entry_0   = $signed(rsp.entry[0]);
   assign rsp_entry_1   = $signed(rsp.entry[1]);
   assign rsp_entry_2   = $signed(rsp.entry[2]);
   assign rsp_entry_3   = $signed(rsp.entry[3]);
   assign rsp_entry_4   = $signed(rsp.entry[4]);
   assign rsp_entry_5   = $signed(rsp.entry[5]);
   assign rsp_last_row  = rsp.last;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row_index <= LAST_ROW))
      else $error("row index out of range");

   a_cfg_stall: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> req_stall)
      else $error("request taken while constants recompute");

   a_busy_no_transfer: assert property (@(posedge clock) disable iff (reset)
      lame.busy |-> !(req_valid && !req_stall))
      else $error("request transfer during constant computation");

endmodule
